### rtl/pfdc_pkg.sv
// Shared constants, types and state codes of the PWM duty and frequency capture unit.
package pfdc_pkg;

   localparam int COUNT_WIDTH    = 16;
   localparam int OUT_WIDTH      = 16;
   localparam int DUTY_WIDTH     = 7;
   localparam int RATE_WIDTH     = 24;
   localparam int PRODUCT_WIDTH  = OUT_WIDTH + DUTY_WIDTH;
   localparam int DIV_NUM_WIDTH  = RATE_WIDTH;
   localparam int DIV_STEP_WIDTH = $clog2(DIV_NUM_WIDTH);
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [DUTY_WIDTH-1:0] PERCENT    = DUTY_WIDTH'(100);
   localparam logic [RATE_WIDTH-1:0] RATE_RESET = RATE_WIDTH'(1000000);
   localparam logic [OUT_WIDTH-1:0]  OUT_MAX    = '1;

   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_RATE   = 1'b1;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] period;
      logic [OUT_WIDTH-1:0] off;
      logic                 err;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   typedef struct packed {
      logic                     start;
      logic [DIV_NUM_WIDTH-1:0] numerator;
      logic [OUT_WIDTH-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic [DIV_NUM_WIDTH-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCALE,
      BK_DUTY_START,
      BK_DUTY_WAIT,
      BK_FREQ_START,
      BK_FREQ_WAIT,
      BK_EMIT
   } back_state_type;

endpackage

### rtl/pfdc_req_if.sv
// Input channel: one timer tick carrying the sampled pin level.
interface pfdc_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink (input valid, input pin_level, output ready);
endinterface

### rtl/pfdc_rsp_if.sv
// Result channel: period, off time, duty, frequency and error flag.
interface pfdc_rsp_if;
   import pfdc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OUT_WIDTH-1:0]  period_ticks;
   logic [OUT_WIDTH-1:0]  off_ticks;
   logic [DUTY_WIDTH-1:0] duty_percent;
   logic [OUT_WIDTH-1:0]  frequency;
   logic                  measure_error;

   modport source (output valid, output period_ticks, output off_ticks,
                   output duty_percent, output frequency, output measure_error,
                   input ready);
   modport sink (input valid, input period_ticks, input off_ticks,
                 input duty_percent, input frequency, input measure_error,
                 output ready);
endinterface

### rtl/pwm_duty_frequency_capture_unit.sv
// Top level of the PWM duty and frequency capture unit with its register port.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        pin_level
//   rsp_chan  out        valid/ready        period_ticks, off_ticks, duty_percent,
//                                            frequency, measure_error
//   csr_*     in         APB psel/penable   capture_enable @0x0, tick_rate @0x4
//
// A tick is taken every cycle while the 4-entry job queue has room.
// Each error-free period takes the back end through one multiply stage and
// two 24-step passes through the shared bit-serial divider; error jobs skip both.
// Periods shorter than that work fill the queue and then drop req_chan.ready.
// A held result stalls the back end first; reset is synchronous and needs no sweep.
module pwm_duty_frequency_capture_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   pfdc_req_if.sink                              req_chan,
   pfdc_rsp_if.source                            rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pfdc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [pfdc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [pfdc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import pfdc_pkg::*;

   logic                  enable_ff, enable_in;
   logic [RATE_WIDTH-1:0] rate_ff, rate_in;

   logic           csr_write;
   logic           csr_sel;
   job_push_type   push;
   queue_head_type head;
   logic           queue_full;
   logic           pop;
   div_req_type    div_req;
   div_rsp_type    div_rsp;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_paddr[2];

   always_comb begin
      enable_in = enable_ff;
      rate_in   = rate_ff;
      if (csr_write) begin
         case (csr_sel)
            CSR_ENABLE: enable_in = csr_pwdata[0];
            CSR_RATE:   rate_in   = csr_pwdata[RATE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_ENABLE: csr_prdata = CSR_DATA_WIDTH'(enable_ff);
         CSR_RATE:   csr_prdata = CSR_DATA_WIDTH'(rate_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         rate_ff   <= RATE_RESET;
      end else begin
         enable_ff <= enable_in;
         rate_ff   <= rate_in;
      end
   end

   pfdc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .capture_enable (enable_ff),
      .queue_full     (queue_full),
      .push           (push)
   );

   pfdc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   pfdc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pfdc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .tick_rate (rate_ff),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_chan  (rsp_chan)
   );

endmodule

### rtl/pfdc_front.sv
// Front end: edge detection, tick counter and capture of period and off time.
module pfdc_front (
   input  logic                  clock,
   input  logic                  reset,
   pfdc_req_if.sink              req_chan,
   input  logic                  capture_enable,
   input  logic                  queue_full,
   output pfdc_pkg::job_push_type push
);
   import pfdc_pkg::*;

   logic                   prev_ff, prev_in;
   logic                   await_ff, await_in;
   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic [COUNT_WIDTH-1:0] off_ff, off_in;
   logic                   ovf_ff, ovf_in;

   logic        accept;
   logic        rising;
   logic        falling;
   logic [32:0] period_ext;
   logic [32:0] off_ext;
   logic        period_over;
   logic        off_over;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rising         = !prev_ff && req_chan.pin_level;
   assign falling        = prev_ff && !req_chan.pin_level;

   assign period_ext  = 33'(counter_ff);
   assign off_ext     = 33'(off_ff);
   assign period_over = period_ext > 33'(OUT_MAX);
   assign off_over    = off_ext > 33'(OUT_MAX);

   always_comb begin
      prev_in    = prev_ff;
      await_in   = await_ff;
      counter_in = counter_ff;
      off_in     = off_ff;
      ovf_in     = ovf_ff;
      push.valid = 1'b0;
      push.job.period = period_over ? OUT_MAX : period_ext[OUT_WIDTH-1:0];
      push.job.off    = off_over ? OUT_MAX : off_ext[OUT_WIDTH-1:0];
      push.job.err    = ovf_ff || (counter_ff == '0) || period_over || off_over;
      if (accept) begin
         prev_in = req_chan.pin_level;
         if (capture_enable) begin
            if (falling && await_ff) begin
               push.valid = 1'b1;
               counter_in = '0;
               ovf_in     = 1'b0;
               await_in   = 1'b0;
            end else begin
               if (rising && !await_ff) begin
                  off_in   = counter_ff;
                  await_in = 1'b1;
               end
               if (counter_ff == '1) begin
                  ovf_in = 1'b1;
               end else begin
                  counter_in = counter_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b0;
         await_ff   <= 1'b0;
         counter_ff <= '0;
         off_ff     <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         prev_ff    <= prev_in;
         await_ff   <= await_in;
         counter_ff <= counter_in;
         off_ff     <= off_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

### rtl/pfdc_queue.sv
// Short job queue between the capture front end and the arithmetic back end.
module pfdc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  pfdc_pkg::job_push_type  push,
   input  logic                    pop,
   output pfdc_pkg::queue_head_type head,
   output logic                    full
);
   import pfdc_pkg::*;

   job_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full       = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("job pushed into full queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head.valid))
      else $error("job popped from empty queue");
`endif

endmodule

### rtl/pfdc_div.sv
// Restoring divider, one quotient bit per cycle.
module pfdc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pfdc_pkg::div_req_type div_req,
   output pfdc_pkg::div_rsp_type div_rsp
);
   import pfdc_pkg::*;

   logic [DIV_NUM_WIDTH-1:0]  work_ff, work_in;
   logic [OUT_WIDTH-1:0]      rem_ff, rem_in;
   logic [OUT_WIDTH-1:0]      divisor_ff, divisor_in;
   logic [DIV_STEP_WIDTH-1:0] step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [OUT_WIDTH:0] trial;
   logic [OUT_WIDTH:0] diff;

   assign trial = {rem_ff, work_ff[DIV_NUM_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         work_in    = div_req.numerator;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         step_in    = DIV_STEP_WIDTH'(DIV_NUM_WIDTH - 1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (!diff[OUT_WIDTH]) begin
            rem_in  = diff[OUT_WIDTH-1:0];
            work_in = {work_ff[DIV_NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = trial[OUT_WIDTH-1:0];
            work_in = {work_ff[DIV_NUM_WIDTH-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> divisor_ff != '0)
      else $error("division by zero period");
`endif

endmodule

### rtl/pfdc_back.sv
// Back end: duty and frequency arithmetic and the result output register.
module pfdc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  pfdc_pkg::queue_head_type          head,
   output logic                              pop,
   input  logic [pfdc_pkg::RATE_WIDTH-1:0]   tick_rate,
   output pfdc_pkg::div_req_type             div_req,
   input  pfdc_pkg::div_rsp_type             div_rsp,
   pfdc_rsp_if.source                        rsp_chan
);
   import pfdc_pkg::*;

   back_state_type state_ff, state_in;

   job_type                 job_ff, job_in;
   logic [PRODUCT_WIDTH-1:0] product_ff, product_in;
   logic [DUTY_WIDTH-1:0]   duty_ff, duty_in;
   logic [OUT_WIDTH-1:0]    freq_ff, freq_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]    rsp_period_ff;
   logic [OUT_WIDTH-1:0]    rsp_off_ff;
   logic [DUTY_WIDTH-1:0]   rsp_duty_ff;
   logic [OUT_WIDTH-1:0]    rsp_freq_ff;
   logic                    rsp_err_ff;

   logic                    load_rsp;
   logic                    slot_free;
   logic [OUT_WIDTH-1:0]    high_ticks;

   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign high_ticks = job_ff.period - job_ff.off;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               state_in = head.job.err ? BK_EMIT : BK_SCALE;
            end
         end
         BK_SCALE:      state_in = BK_DUTY_START;
         BK_DUTY_START: state_in = BK_DUTY_WAIT;
         BK_DUTY_WAIT: begin
            if (div_rsp.done) begin
               state_in = BK_FREQ_START;
            end
         end
         BK_FREQ_START: state_in = BK_FREQ_WAIT;
         BK_FREQ_WAIT: begin
            if (div_rsp.done) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop               = 1'b0;
      load_rsp          = 1'b0;
      div_req.start     = 1'b0;
      div_req.numerator = DIV_NUM_WIDTH'(product_ff);
      div_req.divisor   = job_ff.period;
      job_in            = job_ff;
      product_in        = product_ff;
      duty_in           = duty_ff;
      freq_in           = freq_ff;
      case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               job_in  = head.job;
               duty_in = '0;
               freq_in = '0;
            end
         end
         BK_SCALE: begin
            if (job_ff.off <= job_ff.period) begin
               product_in = PRODUCT_WIDTH'(high_ticks) * PRODUCT_WIDTH'(PERCENT);
            end else begin
               product_in = '0;
            end
         end
         BK_DUTY_START: begin
            div_req.start = 1'b1;
         end
         BK_DUTY_WAIT: begin
            if (div_rsp.done) begin
               duty_in = div_rsp.quotient[DUTY_WIDTH-1:0];
            end
         end
         BK_FREQ_START: begin
            div_req.start     = 1'b1;
            div_req.numerator = tick_rate;
         end
         BK_FREQ_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient > DIV_NUM_WIDTH'(OUT_MAX)) begin
                  freq_in = OUT_MAX;
               end else begin
                  freq_in = div_rsp.quotient[OUT_WIDTH-1:0];
               end
            end
         end
         BK_EMIT: begin
            load_rsp = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      product_ff <= product_in;
      duty_ff    <= duty_in;
      freq_ff    <= freq_in;
      if (load_rsp) begin
         rsp_period_ff <= job_ff.period;
         rsp_off_ff    <= job_ff.off;
         rsp_duty_ff   <= duty_ff;
         rsp_freq_ff   <= freq_ff;
         rsp_err_ff    <= job_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.period_ticks  = rsp_period_ff;
   assign rsp_chan.off_ticks     = rsp_off_ff;
   assign rsp_chan.duty_percent  = rsp_duty_ff;
   assign rsp_chan.frequency     = rsp_freq_ff;
   assign rsp_chan.measure_error = rsp_err_ff;

`ifndef NO_ASSERTIONS
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_duty_ff == '0 && rsp_freq_ff == '0)
      else $error("error result carries nonzero duty or frequency");
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_duty_ff <= PERCENT)
      else $error("duty above one hundred percent");
   a_divider_idle_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> !div_rsp.done)
      else $error("new job taken while a division completes");
`endif

endmodule

### tb/pwm_duty_frequency_capture_unit_tb.sv
// Self-checking testbench of the PWM duty and frequency capture unit.
module pwm_duty_frequency_capture_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfdc_pkg::*;

   localparam int HALF_PERIOD      = 10;
   localparam int RESET_CYCLES     = 6;
   localparam int IDLE_LIMIT       = 4000;
   localparam int SETTLE_CYCLES    = 100;
   localparam int RANDOM_TICKS     = 1300;
   localparam int QUIET_TICKS      = 300;

   typedef struct packed {
      logic [OUT_WIDTH-1:0]  period;
      logic [OUT_WIDTH-1:0]  off;
      logic [DUTY_WIDTH-1:0] duty;
      logic [OUT_WIDTH-1:0]  frequency;
      logic                  err;
   } measurement_type;

   class measurement_board;
      bit                     enabled    = 1'b0;
      logic [RATE_WIDTH-1:0]  rate       = RATE_RESET;
      bit                     last_level = 1'b0;
      bit                     await_fall = 1'b0;
      logic [COUNT_WIDTH-1:0] ticks      = '0;
      logic [COUNT_WIDTH-1:0] off_hold   = '0;
      bit                     saturated  = 1'b0;
      measurement_type        expected[$];
      int unsigned            mismatches = 0;
      int unsigned            received   = 0;

      function void apply_reg(logic idx, logic [CSR_DATA_WIDTH-1:0] value);
         if (idx == CSR_ENABLE) begin
            enabled = value[0];
         end else begin
            rate = value[RATE_WIDTH-1:0];
         end
      endfunction

      function void note_tick(logic level);
         measurement_type m;
         logic            rise;
         logic            fall;
         int unsigned     span;
         int unsigned     quotient;
         rise = !last_level && level;
         fall = last_level && !level;
         last_level = level;
         if (!enabled) return;
         if (rise && !await_fall) begin
            off_hold = ticks;
            await_fall = 1'b1;
         end else if (fall && await_fall) begin
            span = ticks;
            m.period = ticks;
            m.off = off_hold;
            m.err = saturated || (span == 0);
            m.duty = '0;
            m.frequency = '0;
            if (!m.err) begin
               if (off_hold <= ticks) begin
                  m.duty = DUTY_WIDTH'(((span - off_hold) * int'(PERCENT)) / span);
               end
               quotient = rate / span;
               m.frequency = (quotient > OUT_MAX) ? OUT_MAX : OUT_WIDTH'(quotient);
            end
            expected.push_back(m);
            ticks = '0;
            saturated = 1'b0;
            await_fall = 1'b0;
            return;
         end
         if (ticks == '1) begin
            saturated = 1'b1;
         end else begin
            ticks = ticks + 1'b1;
         end
      endfunction

      function void check_measurement(measurement_type got);
         measurement_type want;
         received++;
         if (expected.size() == 0) begin
            $error("measurement with none expected: period_ticks %0d off_ticks %0d",
                   got.period, got.off);
            mismatches++;
            return;
         end
         want = expected.pop_front();
         if (got.period !== want.period) begin
            $error("period_ticks: expected %0d, actual %0d", want.period, got.period);
            mismatches++;
         end
         if (got.off !== want.off) begin
            $error("off_ticks: expected %0d, actual %0d", want.off, got.off);
            mismatches++;
         end
         if (got.duty !== want.duty) begin
            $error("duty_percent: expected %0d, actual %0d", want.duty, got.duty);
            mismatches++;
         end
         if (got.frequency !== want.frequency) begin
            $error("frequency: expected %0d, actual %0d", want.frequency, got.frequency);
            mismatches++;
         end
         if (got.err !== want.err) begin
            $error("measure_error: expected %0d, actual %0d", want.err, got.err);
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   pfdc_req_if req_if ();
   pfdc_rsp_if rsp_if ();

   measurement_board board = new();
   bit               src_gaps = 1'b0;
   bit               snk_gaps = 1'b0;
   int unsigned      total_ticks = 0;
   int unsigned      enabled_ticks = 0;
   int unsigned      stalled_cycles = 0;

   pwm_duty_frequency_capture_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   function automatic int unsigned pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 12);
      if (r < 95) return $urandom_range(13, 120);
      return $urandom_range(121, 400);
   endfunction

   task automatic write_reg(input logic idx, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.apply_reg(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_tick(input logic level);
      if (src_gaps && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pin_level <= level;
      do @(posedge clock); while (!req_if.ready);
      total_ticks++;
      if (board.enabled) enabled_ticks++;
      board.note_tick(level);
   endtask

   task automatic send_run(input logic level, input int unsigned count);
      repeat (count) send_tick(level);
   endtask

   // drain all pending measurements, then let the back end go quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      while (board.expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always begin
      @(posedge clock);
      if (snk_gaps && $urandom_range(0, 7) == 0) begin
         rsp_if.ready <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         board.check_measurement(measurement_type'({rsp_if.period_ticks, rsp_if.off_ticks,
                                                    rsp_if.duty_percent, rsp_if.frequency,
                                                    rsp_if.measure_error}));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned random_base;
      int unsigned phase_end;
      bit          quiet;
      logic [CSR_DATA_WIDTH-1:0] rate_value;

      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.pin_level <= 1'b0;
      rsp_if.ready <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      src_gaps = 1'b1;
      snk_gaps = 1'b1;
      // capture off: pin level is tracked, nothing measured
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      settle();
      write_reg(CSR_ENABLE, 1);
      write_reg(CSR_RATE, 1000);
      // falling edge while waiting for rising is dropped
      send_tick(1'b0);
      send_run(1'b1, 3);
      send_tick(1'b0);
      // one-tick period: full duty
      send_tick(1'b1);
      send_tick(1'b0);
      // long off time: duty truncates to zero
      send_run(1'b0, 105);
      send_tick(1'b1);
      send_tick(1'b0);
      settle();
      write_reg(CSR_RATE, 32'h00FF_FFFF);
      // frequency saturates
      send_tick(1'b1);
      send_tick(1'b0);
      settle();
      write_reg(CSR_RATE, 0);
      send_run(1'b1, 2);
      send_tick(1'b0);
      // rising edge opens a period that stays open across capture off
      send_tick(1'b1);
      settle();
      write_reg(CSR_ENABLE, 0);
      send_tick(1'b0);
      settle();
      write_reg(CSR_ENABLE, 1);
      send_tick(1'b1);
      send_tick(1'b0);
      settle();

      random_base = enabled_ticks;
      while (enabled_ticks - random_base < RANDOM_TICKS) begin
         quiet = (enabled_ticks - random_base + QUIET_TICKS >= RANDOM_TICKS);
         settle();
         src_gaps = !quiet && ($urandom_range(0, 3) != 0);
         snk_gaps = !quiet && ($urandom_range(0, 3) != 0);
         write_reg(CSR_ENABLE, (quiet || $urandom_range(0, 4) != 0) ? 1 : 0);
         case ($urandom_range(0, 5))
            0: rate_value = 1;
            1: rate_value = 32'h00FF_FFFF;
            2: rate_value = $urandom_range(1, 1000);
            3: rate_value = $urandom_range(1000, 100000);
            default: rate_value = $urandom_range(1, 32'h00FF_FFFF);
         endcase
         write_reg(CSR_RATE, rate_value);
         phase_end = total_ticks + $urandom_range(60, 250);
         while (total_ticks < phase_end) begin
            if ($urandom_range(0, 9) < 8) begin
               send_run(1'b0, pick_len());
               send_run(1'b1, pick_len());
            end else begin
               repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
            end
         end
      end

      req_if.valid <= 1'b0;
      while (board.expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.expected.size() != 0) begin
         $error("%0d measurements never arrived", board.expected.size());
      end
      if (board.mismatches == 0 && board.expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
